@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Item layouts, entry layout, status codes and controller/datapath command types.
// No dependencies.
package spq_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Action codes
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic        [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_READ,
    S_INS_WALK,
    S_INS_PUT,
    S_EXT_READ,
    S_EXT_WALK,
    S_RESULT
  } state_t;

  // Read address select
  typedef enum logic [1:0] {
    RA_TOP,   // last stored slot
    RA_ZERO,  // slot 0
    RA_DOWN,  // cur - 1
    RA_UP     // cur + 1
  } rd_sel_t;

  // Write address select
  typedef enum logic [1:0] {
    WA_ZERO,  // slot 0
    WA_DOWN,  // cur - 1
    WA_UP     // cur + 1
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;  // take the new item, prime the result
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    wr_new;     // write the held item rather than the read data
    logic    cap_head;   // capture read data as the extracted entry
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic extract;   // action of the item at the input
    logic full;
    logic empty;
    logic less;      // read entry key is below the held key
    logic cur_zero;
    logic cur_last;
    logic out_free;
  } stat_t;

endpackage

@@ sv/spq_ctrl.sv @@
// Controller state machine for the sorted priority queue.
// Sequences the insert walk and the extract shift; depends on spq_pkg.
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (stat.extract) begin
            state_next = stat.empty ? S_RESULT : S_EXT_READ;
          end else if (stat.full) begin
            state_next = S_RESULT;
          end else begin
            state_next = stat.empty ? S_INS_PUT : S_INS_READ;
          end
        end
      end
      S_INS_READ: state_next = S_INS_WALK;
      S_INS_WALK: begin
        if (stat.less) begin
          state_next = S_RESULT;
        end else if (stat.cur_zero) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT:  state_next = S_RESULT;
      S_EXT_READ: state_next = S_EXT_WALK;
      S_EXT_WALK: begin
        if (stat.cur_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RA_ZERO;
    cmd.wr_sel = WA_ZERO;
    req_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_item = req_valid;
      end
      S_INS_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_TOP;
      end
      S_INS_WALK: begin
        // Shift an entry not below the new key up one slot, or drop the new one in above it
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_UP;
        if (stat.less) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else if (!stat.cur_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_DOWN;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WA_ZERO;
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_EXT_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_ZERO;
      end
      S_EXT_WALK: begin
        // Head goes to the result, every later entry moves down one slot
        if (stat.cur_zero) begin
          cmd.cap_head = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WA_DOWN;
        end
        if (stat.cur_last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_UP;
        end
      end
      S_RESULT: begin
        cmd.res_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/spq_datapath.sv @@
// Datapath for the sorted priority queue: entry memory, walk pointer,
// entry count, held item and output register; depends on spq_pkg.
module spq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spq_pkg::rsp_t  rsp,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat
);
  import spq_pkg::*;

  entry_t             mem [CAPACITY];
  entry_t             rdata;
  logic [IDX_W-1:0]   cur;
  logic [CNT_W-1:0]   count;
  req_t               item;
  logic [1:0]         res_status;
  logic signed [31:0] res_key;
  logic signed [31:0] res_value;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  // Address and data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RA_TOP:  rd_addr = IDX_W'(count - CNT_W'(1));
      RA_ZERO: rd_addr = '0;
      RA_DOWN: rd_addr = cur - IDX_W'(1);
      RA_UP:   rd_addr = cur + IDX_W'(1);
      default: rd_addr = '0;
    endcase
    unique case (cmd.wr_sel)
      WA_ZERO: wr_addr = '0;
      WA_DOWN: wr_addr = cur - IDX_W'(1);
      WA_UP:   wr_addr = cur + IDX_W'(1);
      default: wr_addr = '0;
    endcase
    wr_data = cmd.wr_new ? entry_t'{key: item.key, value: item.value} : rdata;
  end

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Walk pointer follows the last read address
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cur <= rd_addr;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  // Held item and pending result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item      <= req;
      res_key   <= '0;
      res_value <= '0;
      if (req.action == ACT_EXTRACT && stat.empty) begin
        res_status <= ST_EMPTY;
      end else if (req.action == ACT_INSERT && stat.full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_DONE;
      end
    end else if (cmd.cap_head) begin
      res_key   <= rdata.key;
      res_value <= rdata.value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.status      <= res_status;
      rsp.out_key     <= res_key;
      rsp.out_value   <= res_value;
      rsp.entry_count <= 5'(count);
    end
  end

  // Status to the controller
  always_comb begin
    stat.extract  = (req.action == ACT_EXTRACT);
    stat.full     = (count == CNT_W'(CAPACITY));
    stat.empty    = (count == '0);
    stat.less     = (rdata.key < item.key);
    stat.cur_zero = (cur == '0);
    stat.cur_last = (cur == IDX_W'(count - CNT_W'(1)));
    stat.out_free = !rsp_valid || !rsp_stall;
  end

endmodule

@@ sv/sorted_priority_queue.sv @@
// Bounded min-priority queue of key/value entries kept in ascending key order.
// An insert walks down from the last stored entry, moving each entry whose key is not
// below the new one up one slot, and writes the new item above the first lower key or
// into slot 0; an extract returns slot 0 and moves every later entry down one slot. A
// full insert or an empty extract goes straight to the result. A new item is taken only
// in the idle state, entered as the last result moves into the output register.
// Synchronous reset empties the queue and clears the output; memory is not cleared.
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  spq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// Self-checking testbench for sorted_priority_queue: a shadow copy of the ordered
// key/value store predicts each result, and every result is checked in order.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  sorted_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow of the queue contents, kept in ascending key order
  logic signed [31:0] shadow_keys   [CAPACITY];
  logic signed [31:0] shadow_values [CAPACITY];
  int                 shadow_count;
  rsp_t               pending_results [$];

  int failures    = 0;
  int stall_pct   = 0;   // receiver stall probability, percent
  int hold_cycles = 0;   // long receiver hold-off, counted down per cycle
  int gap_max     = 0;   // longest sender gap; zero means back to back
  int burst_left  = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_stall = 1'b1;
        hold_cycles--;
      end else begin
        rsp_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Apply one item to the shadow queue and return the result it should give
  function automatic rsp_t queue_result(req_t it);
    rsp_t               r;
    logic signed [31:0] new_key;
    int                 pos;
    int                 i;
    r       = '0;
    new_key = it.key;
    pos     = 0;
    if (it.action == ACT_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // in front of the first key that is equal or greater
        while (pos < shadow_count && shadow_keys[pos] < new_key) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i]   = shadow_keys[i - 1];
          shadow_values[i] = shadow_values[i - 1];
        end
        shadow_keys[pos]   = new_key;
        shadow_values[pos] = it.value;
        shadow_count++;
        r.status = ST_DONE;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status    = ST_DONE;
      r.out_key   = shadow_keys[0];
      r.out_value = shadow_values[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_keys[i - 1]   = shadow_keys[i];
        shadow_values[i - 1] = shadow_values[i];
      end
      shadow_count--;
    end
    r.entry_count = 5'(shadow_count);
    return r;
  endfunction

  function automatic void report_failure(string what, rsp_t want, rsp_t got);
    failures++;
    if (failures <= 10)
      $display({"%0t %s: expected st %0d key %0d val %0d cnt %0d,",
                " got st %0d key %0d val %0d cnt %0d"},
               $realtime, what, want.status, $signed(want.out_key), $signed(want.out_value),
               want.entry_count, got.status, $signed(got.out_key), $signed(got.out_value),
               got.entry_count);
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", '0, rsp);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status || rsp.out_key !== want.out_key ||
            rsp.out_value !== want.out_value || rsp.entry_count !== want.entry_count)
          report_failure("result mismatch", want, rsp);
      end
    end
  end

  function automatic req_t make_item(logic act, logic signed [31:0] k, logic signed [31:0] v);
    req_t it;
    it.action = act;
    it.key    = k;
    it.value  = v;
    return it;
  endfunction

  // Mix of narrow keys (many ties), full-range keys and extremes
  function automatic logic signed [31:0] random_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 5))
      0, 1:    k = int'($urandom_range(0, 8)) - 4;
      2, 3:    k = $urandom;
      4:       k = ($urandom_range(0, 1) != 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: k = ($urandom_range(0, 1) != 0) ? 32'sh0000_0000 : -32'sd1;
    endcase
    return k;
  endfunction

  // Sender idles with valid low; payload is don't-care meanwhile
  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid = 1'b0;
      req       = make_item(1'($urandom_range(0, 1)), $urandom, $urandom);
    end
  endtask

  // Offer one item, wait for it to be taken, record its expected result
  task automatic send_item(req_t it);
    if (gap_max > 0 && burst_left == 0) begin
      idle_sender($urandom_range(1, gap_max));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    req_valid = 1'b1;
    req       = it;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(queue_result(it));
  endtask

  task automatic test_empty_extract();
    send_item(make_item(ACT_EXTRACT, '1, '0));
  endtask

  // Extreme keys, signed ordering, and ties leaving newest first
  task automatic test_key_ordering();
    send_item(make_item(ACT_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_item(make_item(ACT_INSERT, 32'sh8000_0000, 32'sh8000_0000));
    send_item(make_item(ACT_INSERT, 32'sd0, 32'sd0));
    send_item(make_item(ACT_INSERT, -32'sd1, -32'sd1));
    send_item(make_item(ACT_INSERT, 32'sd1, 32'sh5555_5555));
    send_item(make_item(ACT_INSERT, 32'sd5, 32'sd1));
    send_item(make_item(ACT_INSERT, 32'sd5, 32'sd2));
    send_item(make_item(ACT_INSERT, 32'sd5, 32'shaaaa_aaaa));
    repeat (9) send_item(make_item(ACT_EXTRACT, '0, '1));
  endtask

  // Fill to capacity, overfill, then drain past empty
  task automatic test_full_queue();
    repeat (CAPACITY - shadow_count) send_item(make_item(ACT_INSERT, random_key(), $urandom));
    repeat (3) send_item(make_item(ACT_INSERT, random_key(), $urandom));
    repeat (CAPACITY + 1) send_item(make_item(ACT_EXTRACT, $urandom, $urandom));
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    gap_max     = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    repeat (24) send_item(make_item(ACT_INSERT, random_key(), $urandom));
    repeat (24) send_item(make_item(ACT_EXTRACT, $urandom, $urandom));
  endtask

  // Phases that lean to inserts or extracts, with varied idling on both sides
  task automatic test_random_traffic();
    int ins_pct;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      case (phase % 4)
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
      gap_max    = (phase % 5 == 0) ? 0 : $urandom_range(2, 8);
      burst_left = 0;
      repeat (135) begin
        if ($urandom_range(99) < ins_pct)
          send_item(make_item(ACT_INSERT, random_key(), $urandom));
        else
          send_item(make_item(ACT_EXTRACT, $urandom, $urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    int waited;
    req_valid    = 1'b0;
    req          = '0;
    rst          = 1'b1;
    shadow_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_extract();
    test_key_ordering();
    test_full_queue();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    req_valid = 1'b0;
    stall_pct = 0;
    waited    = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (CAPACITY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      failures += pending_results.size();
    end
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
